/* rtl/aram_pkg.sv */
// Shared types and constants for the aliased RAM access unit.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package aram_pkg;

  // Backing RAM geometry; the size must be a power of two.
  localparam int unsigned RAM_BYTES = 32'd16777216;
  localparam int unsigned RAM_WORDS = RAM_BYTES / 4;
  localparam int unsigned OFF_W     = $clog2(RAM_BYTES);
  localparam int unsigned WIDX_W    = OFF_W - 2;

  // Width of the configuration data port (widest register).
  localparam int unsigned CFG_W = 33;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 40;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PHYS_BASE   = 2'd0,
    REG_CACHED_BASE = 2'd1,
    REG_UNCACH_BASE = 2'd2,
    REG_ALIAS_SPAN  = 2'd3
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISALIGN = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  // Access size codes.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0]      PHYS_BASE_RST   = 32'h0C00_0000;
  localparam logic [31:0]      CACHED_BASE_RST = 32'h8C00_0000;
  localparam logic [31:0]      UNCACH_BASE_RST = 32'hAC00_0000;
  localparam logic [CFG_W-1:0] ALIAS_SPAN_RST  = 33'h0_0400_0000;

  // Classified access handed from the front end to the back end.
  typedef struct packed {
    status_t           status;
    logic              is_write;
    logic [WIDX_W-1:0] widx;
    logic [1:0]        lane;     // byte offset within the word
    logic [3:0]        size_be;  // byte lanes of the size, unshifted
    logic [3:0]        wr_be;    // byte lanes written, shifted into place
    logic [31:0]       wr_data;  // write data shifted into place
  } cmd_t;

  // Byte lanes covered by an access of the given size.
  function automatic logic [3:0] size_lanes(input logic [1:0] size);
    logic [3:0] be;
    case (size)
      SZ_BYTE: be = 4'b0001;
      SZ_HALF: be = 4'b0011;
      SZ_WORD: be = 4'b1111;
      default: be = 4'b0000;
    endcase
    return be;
  endfunction

endpackage

`default_nettype wire

/* rtl/aram_front.sv */
// Front end: holds the configuration registers, takes input beats,
// checks alignment and decodes the alias windows into RAM commands.
// Depends on aram_pkg.
`default_nettype none

module aram_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [aram_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [aram_pkg::S_DATA_W-1:0] s_tdata,
  input  wire logic                          ram_ready,
  input  wire logic                          q_full,
  output logic                               push,
  output aram_pkg::cmd_t                     cmd
);
  import aram_pkg::*;

  logic [31:0]      physical_base;
  logic [31:0]      cached_base;
  logic [31:0]      uncached_base;
  logic [CFG_W-1:0] alias_span;

  logic        hold_valid;
  logic        hold_op;
  logic [1:0]  hold_size;
  logic [31:0] hold_addr;
  logic [31:0] hold_wdata;

  logic [31:0]      bases [3];
  logic [2:0]       hit;
  logic [31:0]      rel [3];
  logic [OFF_W-1:0] off;
  logic             misalign;
  logic [7:0]       be_wide;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      physical_base <= PHYS_BASE_RST;
      cached_base   <= CACHED_BASE_RST;
      uncached_base <= UNCACH_BASE_RST;
      alias_span    <= ALIAS_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHYS_BASE:   physical_base <= cfg_wdata[31:0];
        REG_CACHED_BASE: cached_base   <= cfg_wdata[31:0];
        REG_UNCACH_BASE: uncached_base <= cfg_wdata[31:0];
        REG_ALIAS_SPAN:  alias_span    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input holding register; a new beat enters as the held one moves on.
  assign push     = hold_valid && !q_full;
  assign s_tready = ram_ready && (!hold_valid || push);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_op    <= s_tdata[0];
      hold_size  <= s_tdata[2:1];
      hold_addr  <= s_tdata[34:3];
      hold_wdata <= s_tdata[66:35];
    end
  end

  // Alignment check; size code three is rejected here as well.
  assign misalign = (hold_size == 2'd3) ||
                    (hold_size == SZ_HALF && hold_addr[0]) ||
                    (hold_size == SZ_WORD && hold_addr[1:0] != 2'b00);

  // The three window compares run side by side.
  assign bases[0] = physical_base;
  assign bases[1] = cached_base;
  assign bases[2] = uncached_base;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rel[i] = hold_addr - bases[i];
      hit[i] = (hold_addr >= bases[i]) && ({1'b0, rel[i]} < alias_span);
    end
  end

  // Priority pick of the first matching window, folded into the RAM.
  always_comb begin
    if (hit[0]) begin
      off = rel[0][OFF_W-1:0];
    end else if (hit[1]) begin
      off = rel[1][OFF_W-1:0];
    end else begin
      off = rel[2][OFF_W-1:0];
    end
  end

  // Build the command, with lanes and data already shifted into place.
  assign be_wide = {4'b0000, size_lanes(hold_size)} << off[1:0];

  always_comb begin
    if (misalign) begin
      cmd.status = ST_MISALIGN;
    end else if (hit == 3'b000) begin
      cmd.status = ST_OUTSIDE;
    end else begin
      cmd.status = ST_OK;
    end
    cmd.is_write = (hold_op == OP_WRITE);
    cmd.widx     = off[OFF_W-1:2];
    cmd.lane     = off[1:0];
    cmd.size_be  = size_lanes(hold_size);
    cmd.wr_be    = be_wide[3:0];
    cmd.wr_data  = hold_wdata << {off[1:0], 3'b000};
  end

endmodule

`default_nettype wire

/* rtl/aram_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on aram_pkg for the command type.
`default_nettype none

module aram_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire aram_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output aram_pkg::cmd_t      head
);
  import aram_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/aram_back.sv */
// Back end: clears the backing RAM after reset, carries out queued
// commands against it and presents results through an output register.
// Depends on aram_pkg.
`default_nettype none

module aram_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire aram_pkg::cmd_t                head,
  output logic                               pop,
  output logic                               ram_ready,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [aram_pkg::M_DATA_W-1:0]      m_tdata
);
  import aram_pkg::*;

  logic [31:0] ram [RAM_WORDS];

  logic              clearing;
  logic [WIDX_W-1:0] clr_idx;

  logic              mem_we;
  logic [WIDX_W-1:0] mem_addr;
  logic [3:0]        mem_be;
  logic [31:0]       mem_wd;

  logic        s1_valid;
  cmd_t        s1;
  logic [31:0] rd_word;
  logic        s1_adv;
  logic [31:0] rd_shift;
  logic [31:0] rd_mask;
  logic [31:0] result;

  logic [31:0] read_data;
  status_t     status;

  // Clearing pass: one word per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == WIDX_W'(RAM_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_ready = !clearing;

  // Stage handshake: take a command when the stage frees up.
  assign s1_adv = s1_valid && (!m_tvalid || m_tready);
  assign pop    = head_valid && !clearing && (!s1_valid || s1_adv);

  // RAM port selection between the clearing pass and commands.
  always_comb begin
    if (clearing) begin
      mem_we   = 1'b1;
      mem_addr = clr_idx;
      mem_be   = 4'b1111;
      mem_wd   = '0;
    end else begin
      mem_we   = pop && head.is_write && (head.status == ST_OK);
      mem_addr = head.widx;
      mem_be   = head.wr_be;
      mem_wd   = head.wr_data;
    end
  end

  // Backing RAM with byte-lane writes and a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < 4; b++) begin
        if (mem_be[b]) begin
          ram[mem_addr][8*b +: 8] <= mem_wd[8*b +: 8];
        end
      end
    end
    if (pop) begin
      rd_word <= ram[mem_addr];
    end
  end

  // Access stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= head;
    end
  end

  // Align the read word down and keep the lanes of the size.
  assign rd_shift = rd_word >> {s1.lane, 3'b000};
  assign rd_mask  = {{8{s1.size_be[3]}}, {8{s1.size_be[2]}},
                     {8{s1.size_be[1]}}, {8{s1.size_be[0]}}};

  always_comb begin
    if (s1.status == ST_OK && !s1.is_write) begin
      result = rd_shift & rd_mask;
    end else begin
      result = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data <= result;
      status    <= s1.status;
    end
  end

  assign m_tdata = {6'b000000, status, read_data};

endmodule

`default_nettype wire

/* rtl/aliased_ram_access_unit_top.sv */
// Aliased RAM access unit, top level. Depends on aram_pkg and its submodules.
// Path: holding register, queue, access stage, output register.
// Throughput: one access per cycle unless the output stalls, set by the single
// RAM port in the back end. Reset: synchronous; then all 4194304 RAM words are
// cleared one word per cycle, while no input beat is taken (config writes are).
`default_nettype none

module aliased_ram_access_unit_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [aram_pkg::CFG_W-1:0]    cfg_wdata,
  // Access input stream.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // s_tdata, low bit up: opcode[0], size_code[2:1], address[34:3],
  // write_data[66:35], zero padding[71:67].
  input  wire logic [aram_pkg::S_DATA_W-1:0] s_tdata,
  // Result output stream.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // m_tdata, low bit up: read_data[31:0], status[33:32], zero padding[39:34].
  output logic [aram_pkg::M_DATA_W-1:0]      m_tdata
);
  import aram_pkg::*;

  logic ram_ready;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  // Decode side.
  aram_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .ram_ready (ram_ready),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Decoupling queue.
  aram_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Memory side.
  aram_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ram_ready  (ram_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

/* bench/aliased_ram_access_unit_top_tb.sv */
// Self-checking bench for aliased_ram_access_unit_top: directed and random accesses
// through several window settings, checked against a behavioural model of the RAM.
// Depends on aram_pkg and the RTL of the access unit.
`default_nettype none

module aliased_ram_access_unit_top_tb;
  import aram_pkg::*;

  // Size code that no access may use.
  localparam logic [1:0] SZ_BAD = 2'd3;
  localparam int unsigned PAD_W = S_DATA_W - 67;

  // One bus access as it travels on the slave stream.
  typedef struct {
    logic        op;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
  } access_t;

  // The result that an access is due to produce.
  typedef struct {
    logic [31:0] read_data;
    status_t     status;
  } completion_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = REG_PHYS_BASE;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // s_tdata, low bit up: opcode, size_code, address, write_data, zero padding.
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // m_tdata, low bit up: read_data, status, zero padding.
  logic [M_DATA_W-1:0] m_tdata;

  // Model state: window registers and the words written so far.
  logic [31:0]         win_base [0:2];
  logic [CFG_W-1:0]    win_span;
  logic [31:0]         ram_image [int unsigned];

  access_t             pending_items [$];
  completion_t         pending_completions [$];
  access_t             offered;
  completion_t         want;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  error_count = 0;

  aliased_ram_access_unit_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Generous ceiling: the clearing pass alone covers over four million words.
  initial begin
    #60000000;
    $display("aliased_ram_access_unit_top test failed");
    $finish;
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 100) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // Carries out one access on the model RAM and returns what the block should say.
  function automatic completion_t emulate_access(input access_t a);
    completion_t c;
    logic [31:0] off;
    logic [31:0] lanes;
    logic [31:0] word;
    logic [31:0] mask;
    logic [4:0]  shift;
    int unsigned widx;
    bit          found;
    c.read_data = '0;
    c.status    = ST_OK;
    found       = 1'b0;
    off         = '0;
    if (a.size == SZ_BAD || (a.size == SZ_HALF && a.addr[0]) ||
        (a.size == SZ_WORD && a.addr[1:0] != 2'b00)) begin
      c.status = ST_MISALIGN;
      return c;
    end
    // Windows are tried in priority order; the span is compared at 33 bits.
    for (int i = 0; i < 3; i++) begin
      if (!found && a.addr >= win_base[i] &&
          ({1'b0, a.addr} - {1'b0, win_base[i]}) < win_span) begin
        found = 1'b1;
        off   = a.addr - win_base[i];
      end
    end
    if (!found) begin
      c.status = ST_OUTSIDE;
      return c;
    end
    widx  = off[OFF_W-1:2];
    shift = {off[1:0], 3'b000};
    case (a.size)
      SZ_BYTE: lanes = 32'h0000_00FF;
      SZ_HALF: lanes = 32'h0000_FFFF;
      default: lanes = 32'hFFFF_FFFF;
    endcase
    word = ram_image.exists(widx) ? ram_image[widx] : 32'h0;
    if (a.op == OP_WRITE) begin
      mask = lanes << shift;
      ram_image[widx] = (word & ~mask) | ((a.wdata << shift) & mask);
    end else begin
      c.read_data = (word >> shift) & lanes;
    end
    return c;
  endfunction

  function automatic void add_access(input logic op, input logic [1:0] size,
                                     input logic [31:0] addr, input logic [31:0] wdata);
    access_t a;
    a.op    = op;
    a.size  = size;
    a.addr  = addr;
    a.wdata = wdata;
    pending_items.push_back(a);
  endfunction

  // Mostly addresses inside a window, folded onto a few hot spots so that reads
  // find earlier writes; some near window edges and some anywhere at all.
  function automatic logic [31:0] pick_address(input logic [1:0] size);
    longint unsigned off;
    longint unsigned mirrors;
    logic [31:0]     base;
    logic [31:0]     a;
    int unsigned     r;
    r    = $urandom_range(99);
    base = win_base[$urandom_range(2)];
    if (r < 8) begin
      a = $urandom;
    end else if (r < 16) begin
      if ($urandom_range(1) == 1) begin
        a = base + win_span[31:0] - $urandom_range(8);
      end else begin
        a = base - $urandom_range(4, 1);
      end
    end else begin
      case ($urandom_range(3))
        0: off = $urandom_range(RAM_BYTES - 1);
        1: off = RAM_BYTES - 1 - $urandom_range(63);
        default: off = $urandom_range(63);
      endcase
      mirrors = win_span / RAM_BYTES;
      if (mirrors > 1) begin
        off += longint'(RAM_BYTES) * ($urandom % mirrors);
      end
      if (win_span != 0) begin
        off = off % win_span;
      end
      a = base + off[31:0];
    end
    // Most accesses are aligned for their size.
    if ($urandom_range(9) != 0) begin
      if (size == SZ_HALF) a[0] = 1'b0;
      if (size == SZ_WORD) a[1:0] = 2'b00;
    end
    return a;
  endfunction

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_ALIAS_SPAN) begin
      win_span = value;
    end else begin
      win_base[int'(idx)] = value[31:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued beat is taken and every result has come back.
  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid) @(negedge clk);
    while (pending_completions.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Programs the windows, sets the idling pattern and runs a batch of random accesses.
  task automatic run_phase(input logic [31:0] phys, input logic [31:0] cached,
                           input logic [31:0] uncached, input logic [CFG_W-1:0] span,
                           input int count, input int send_pct, input int recv_pct);
    logic [1:0] size;
    write_register(REG_PHYS_BASE, {1'($urandom), phys});
    write_register(REG_CACHED_BASE, {1'($urandom), cached});
    write_register(REG_UNCACH_BASE, {1'($urandom), uncached});
    write_register(REG_ALIAS_SPAN, span);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      size = ($urandom_range(99) < 4) ? SZ_BAD : 2'($urandom_range(2));
      add_access(1'($urandom), size, pick_address(size), $urandom);
    end
    drain();
  endtask

  // Access driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_completions.push_back(emulate_access(offered));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered  = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {PAD_W'(0), offered.wdata, offered.addr, offered.size, offered.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_completions.size() == 0) begin
          flag_error($sformatf("result %h arrived with none pending", m_tdata));
        end else begin
          want = pending_completions.pop_front();
          if (m_tdata[31:0] !== want.read_data) begin
            flag_error($sformatf("read_data %h, predicted %h", m_tdata[31:0],
                                 want.read_data));
          end
          if (m_tdata[33:32] !== want.status) begin
            flag_error($sformatf("status %0d, predicted %0d", m_tdata[33:32],
                                 want.status));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    win_base[0] = PHYS_BASE_RST;
    win_base[1] = CACHED_BASE_RST;
    win_base[2] = UNCACH_BASE_RST;
    win_span    = ALIAS_SPAN_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed accesses with the reset windows: aliases, mirrors, lanes and errors.
    add_access(OP_WRITE, SZ_WORD, 32'h0C00_0000, 32'hFFFF_FFFF);
    add_access(OP_READ,  SZ_WORD, 32'h0C00_0000, 32'h0);
    add_access(OP_WRITE, SZ_BYTE, 32'h8C00_0001, 32'h0000_00A5);
    add_access(OP_READ,  SZ_WORD, 32'hAC00_0000, 32'h0);
    add_access(OP_WRITE, SZ_HALF, 32'h0C00_0002, 32'h1234_5678);
    add_access(OP_READ,  SZ_WORD, 32'h0D00_0000, 32'h0);
    add_access(OP_READ,  SZ_HALF, 32'h8C00_0002, 32'h0);
    add_access(OP_WRITE, SZ_BYTE, 32'h0FFF_FFFF, 32'h0000_0080);
    add_access(OP_READ,  SZ_BYTE, 32'h0CFF_FFFF, 32'h0);
    add_access(OP_READ,  SZ_BYTE, 32'h1000_0000, 32'h0);
    add_access(OP_READ,  SZ_WORD, 32'h0BFF_FFFC, 32'h0);
    // The bad size code must leave memory alone.
    add_access(OP_WRITE, SZ_BAD,  32'h0C00_0000, 32'h0000_0000);
    add_access(OP_READ,  SZ_BAD,  32'h0C00_0000, 32'h0);
    add_access(OP_READ,  SZ_WORD, 32'h0C00_0000, 32'h0);
    add_access(OP_READ,  SZ_HALF, 32'h0C00_0001, 32'h0);
    add_access(OP_WRITE, SZ_WORD, 32'h0C00_0002, 32'hFFFF_FFFF);
    // Misaligned and outside every window: alignment wins.
    add_access(OP_READ,  SZ_WORD, 32'h0000_0003, 32'h0);
    add_access(OP_READ,  SZ_BYTE, 32'h0000_0000, 32'h0);
    add_access(OP_READ,  SZ_BYTE, 32'hFFFF_FFFF, 32'h0);
    add_access(OP_WRITE, SZ_WORD, 32'hAFFF_FFFC, 32'hDEAD_BEEF);
    add_access(OP_READ,  SZ_HALF, 32'h0FFF_FFFE, 32'h0);
    add_access(OP_READ,  SZ_WORD, 32'h8FFF_FFFC, 32'h0);
    drain();

    // Widest span: the first window reaches the top of the address space.
    run_phase(32'h0000_0000, 32'h0100_0000, 32'hFFFF_FF00, 33'h1_0000_0000, 150, 88, 0);
    // Zero span: nothing can match.
    run_phase($urandom, $urandom, $urandom, 33'h0, 40, 0, 88);
    // One-byte windows, two of them on the same base.
    run_phase(32'h4000_0000, 32'h4000_0000, 32'h0000_0002, 33'h1, 40, 38, 38);
    // A span that is not a whole number of mirrors.
    run_phase($urandom, $urandom, $urandom, CFG_W'(3 * RAM_BYTES + 256), 150, 0, 0);
    run_phase(32'hFFFF_FFFC, 32'hFFFF_0000, 32'h8000_0000, 33'h1_0000_0000, 150, 38, 38);
    run_phase($urandom, $urandom, $urandom,
              CFG_W'($urandom_range(4 * RAM_BYTES, RAM_BYTES / 2)), 150, 0, 88);
    // Cached window lies inside the physical one, which takes priority.
    run_phase(32'h2000_0000, 32'h2000_8000, 32'h2100_0000, CFG_W'(2 * RAM_BYTES),
              150, 88, 0);
    run_phase(PHYS_BASE_RST, CACHED_BASE_RST, UNCACH_BASE_RST, ALIAS_SPAN_RST,
              150, 0, 0);

    repeat (10) @(negedge clk);
    if (pending_completions.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_completions.size()));
    end
    if (error_count == 0) begin
      $display("aliased_ram_access_unit_top test passed");
    end else begin
      $display("aliased_ram_access_unit_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
